// ----- rtl/adsr_pkg.sv -----
package adsr_pkg;

    localparam int CURVE_LEN = 512;
    localparam int CURVE_END = 511;
    localparam int DIV_STEPS = 9;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_TRIGGER   = 2'd1;
    localparam logic [1:0] OP_RELEASE   = 2'd2;
    localparam logic [1:0] OP_FORCE_OFF = 2'd3;

    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_DECAY   = 3'd1;
    localparam logic [2:0] PH_SUSTAIN = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_OFF     = 3'd4;

    localparam logic [14:0] LEVEL_MAX   = 15'h7fff;
    localparam logic [15:0] TIMER_MAX   = 16'hffff;
    localparam logic [6:0]  SUSTAIN_MAX = 7'd127;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] channel;
        logic [6:0] attack_rate;
        logic [6:0] decay_rate;
        logic [6:0] sustain_level;
        logic [6:0] release_rate;
    } item_t;

    typedef struct packed {
        logic [2:0]  out_channel;
        logic [14:0] amplitude;
        logic [2:0]  phase;
    } result_t;

    typedef struct packed {
        logic [6:0] rel_rate;
        logic [6:0] sus_level;
        logic [6:0] dec_rate;
        logic [6:0] att_rate;
    } params_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] timer;
        logic [14:0] level;
        params_t     params;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{phase: PH_OFF, timer: '0, level: '0, params: '0};

    typedef logic [7:0] curve_rom_t [CURVE_LEN];

    // Attack curve: floor(isqrt(12544 * i) / 10), i.e. floor(11.2 * sqrt(i)).
    function automatic curve_rom_t build_attack_rom();
        curve_rom_t  rom;
        logic [31:0] v;
        logic [31:0] r;
        logic [31:0] b;
        for (int i = 0; i < CURVE_LEN; i++)
        begin
            v = 32'(12544 * i);
            r = '0;
            b = 32'h4000_0000;
            for (int k = 0; k < 16; k++)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            rom[i] = 8'(r / 10);
        end
        return rom;
    endfunction

    // Decay and release curve: 13950 / (i + 50) - 24, by repeated subtraction.
    function automatic curve_rom_t build_falloff_rom();
        curve_rom_t rom;
        int         n;
        int         q;
        for (int i = 0; i < CURVE_LEN; i++)
        begin
            n = 13950;
            q = 0;
            for (int k = 0; k < 280; k++)
            begin
                if (n >= i + 50)
                begin
                    n = n - (i + 50);
                    q = q + 1;
                end
            end
            rom[i] = 8'(q - 24);
        end
        return rom;
    endfunction

endpackage

// ----- rtl/adsr_ram.sv -----
module adsr_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/adsr_envelope_generator_unit.sv -----
// Multi-channel ADSR envelope generator.
// Input channel (item_valid / item_ready / item): one event per beat, aimed at
// one channel: a tick, a note trigger, a note release or a forced off.
// Output channel (result_valid / result_ready / result): exactly one beat per
// input beat, reporting the channel's amplitude and phase after the event.
// Channel state lives in a single-port-read RAM, one word per channel, and is
// read, modified and written back; one event is in flight at a time.
// A tick in a timed phase short of the curve end divides four times the
// timer by the rate in a restoring divider that produces one quotient bit per
// cycle, then looks up the curve ROM and, in decay and release, applies the
// sustain scaling. Such a tick passes through the read, divide, look-up,
// apply and finish states; other events go from read straight to finish,
// and an event for an absent channel goes straight to finish.
// Reset marks every channel word as unwritten, so each channel reads as off
// with zero level, timer and settings until its first write; no sweep is
// needed. A result waits in the output register while the receiver stalls;
// the next beat may be accepted meanwhile, but its write-back and result
// wait until that register is free.
module adsr_envelope_generator_unit #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  adsr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output adsr_pkg::result_t result
);

    import adsr_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam curve_rom_t ATTACK_ROM  = build_attack_rom();
    localparam curve_rom_t FALLOFF_ROM = build_falloff_rom();

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_LOOK,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic                    miss_reg;
    logic [3:0]              cnt_reg;
    logic                    result_valid_reg;
    result_t                 result_reg;

    logic [1:0]  op_reg;
    logic [2:0]  channel_reg;
    params_t     params_in_reg;
    entry_t      work_reg;
    logic [6:0]  rem_reg;
    logic [8:0]  dvd_low_reg;
    logic [6:0]  rate_reg;
    logic [8:0]  q_reg;
    logic [7:0]  att_val_reg;
    logic [7:0]  fall_val_reg;

    logic        item_fire;
    logic        in_range;
    logic        finish_go;
    logic        ram_wr_en;
    logic        ram_rd_en;
    logic [61:0] ram_rd_data;
    entry_t      read_entry;
    entry_t      work_next;
    logic        go_div;
    logic [6:0]  rate_sel;
    logic [17:0] dividend;
    logic [15:0] limit;
    logic        at_end;
    logic [7:0]  trial;
    logic        trial_ge;
    entry_t      apply_next;
    logic [14:0] decay_scale;
    logic [14:0] release_scale;

    assign item_ready   = (state_reg == S_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign in_range     = (32'(item.channel) < NUM_CHANNELS);
    assign finish_go    = !result_valid_reg || result_ready;
    assign ram_rd_en    = item_fire && in_range;
    assign ram_wr_en    = (state_reg == S_FINISH) && finish_go && !miss_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    adsr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(channel_reg)),
        .wr_data (work_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (AW'(item.channel)),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        read_entry = valid_reg[AW'(channel_reg)] ? entry_t'(ram_rd_data) : ENTRY_RESET;
        case (read_entry.phase)
            PH_ATTACK: rate_sel = read_entry.params.att_rate;
            PH_DECAY:  rate_sel = read_entry.params.dec_rate;
            default:   rate_sel = read_entry.params.rel_rate;
        endcase
        dividend = {read_entry.timer, 2'b00};
        limit    = {rate_sel, 9'b0} - {9'b0, rate_sel};
        at_end   = (dividend >= {2'b00, limit});

        work_next = read_entry;
        go_div    = 1'b0;
        case (op_reg)
            OP_TRIGGER:
            begin
                work_next.phase  = PH_ATTACK;
                work_next.level  = '0;
                work_next.timer  = '0;
                work_next.params = params_in_reg;
            end
            OP_RELEASE:
            begin
                if (read_entry.phase != PH_OFF)
                begin
                    work_next.phase = PH_RELEASE;
                    work_next.timer = '0;
                end
            end
            OP_FORCE_OFF:
            begin
                if (read_entry.phase != PH_OFF)
                begin
                    work_next.phase = PH_OFF;
                    work_next.level = '0;
                    work_next.timer = '0;
                end
            end
            OP_TICK:
            begin
                case (read_entry.phase)
                    PH_ATTACK:
                    begin
                        if (rate_sel == '0)
                        begin
                            work_next.level = LEVEL_MAX;
                            work_next.phase = PH_DECAY;
                        end
                        else if (at_end)
                        begin
                            work_next.level = LEVEL_MAX;
                            work_next.phase = PH_DECAY;
                            work_next.timer = '0;
                        end
                        else
                        begin
                            go_div = 1'b1;
                        end
                    end
                    PH_DECAY:
                    begin
                        if (rate_sel == '0 || at_end)
                        begin
                            work_next.level = {read_entry.params.sus_level, 8'b0};
                            work_next.phase = PH_SUSTAIN;
                        end
                        else
                        begin
                            go_div = 1'b1;
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (rate_sel == '0 || read_entry.timer == TIMER_MAX || at_end)
                        begin
                            work_next.level = '0;
                            work_next.phase = PH_OFF;
                        end
                        else
                        begin
                            go_div = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        trial    = {rem_reg, dvd_low_reg[8]};
        trial_ge = (trial >= {1'b0, rate_reg});

        decay_scale   = 15'(SUSTAIN_MAX - work_reg.params.sus_level) * 15'(fall_val_reg);
        release_scale = 15'(work_reg.params.sus_level) * 15'(fall_val_reg);

        apply_next       = work_reg;
        apply_next.timer = work_reg.timer + 16'd1;
        case (work_reg.phase)
            PH_ATTACK: apply_next.level = {att_val_reg, 7'b0};
            PH_DECAY:  apply_next.level = {work_reg.params.sus_level, 8'b0} + decay_scale;
            default:   apply_next.level = release_scale;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            miss_reg         <= 1'b0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_valid_reg && result_ready && state_reg != S_FINISH)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        miss_reg  <= !in_range;
                        state_reg <= in_range ? S_READ : S_FINISH;
                    end
                end
                S_READ:
                begin
                    cnt_reg   <= 4'(DIV_STEPS - 1);
                    state_reg <= go_div ? S_DIV : S_FINISH;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (finish_go)
                    begin
                        result_valid_reg       <= 1'b1;
                        result_reg.out_channel <= channel_reg;
                        result_reg.amplitude   <= miss_reg ? '0 : work_reg.level;
                        result_reg.phase       <= miss_reg ? PH_OFF : work_reg.phase;
                        if (!miss_reg)
                        begin
                            valid_reg[AW'(channel_reg)] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    op_reg        <= item.op;
                    channel_reg   <= item.channel;
                    params_in_reg <= '{rel_rate: item.release_rate,
                                       sus_level: item.sustain_level,
                                       dec_rate: item.decay_rate,
                                       att_rate: item.attack_rate};
                end
            end
            S_READ:
            begin
                work_reg    <= work_next;
                rem_reg     <= 7'(dividend[17:9]);
                dvd_low_reg <= dividend[8:0];
                rate_reg    <= rate_sel;
                q_reg       <= '0;
            end
            S_DIV:
            begin
                rem_reg     <= trial_ge ? 7'(trial - {1'b0, rate_reg}) : trial[6:0];
                q_reg       <= {q_reg[7:0], trial_ge};
                dvd_low_reg <= {dvd_low_reg[7:0], 1'b0};
            end
            S_LOOK:
            begin
                att_val_reg  <= ATTACK_ROM[q_reg];
                fall_val_reg <= FALLOFF_ROM[q_reg];
            end
            S_APPLY:
            begin
                work_reg <= apply_next;
            end
            default:
            begin
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> !item_ready)
        else $error("Second beat accepted while an event is still in flight.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && 32'(result.out_channel) >= NUM_CHANNELS)
        |-> (result.amplitude == '0 && result.phase == PH_OFF))
        else $error("Absent channel reported a live envelope.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> (q_reg < 9'(CURVE_END)))
        else $error("Curve index reached the end of the table on the lookup path.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> $past(state_reg == S_APPLY || state_reg == S_READ
                            || state_reg == S_FINISH))
        else $error("Channel write-back without a preceding read.");

endmodule

// ----- verif/adsr_envelope_generator_unit_checker.sv -----
`timescale 1ns / 1ps

module adsr_envelope_generator_unit_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  adsr_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  adsr_pkg::result_t result,
    output int                fail_count,
    output int                pending
);

    import adsr_pkg::*;

    logic [7:0]  rise_curve [CURVE_LEN];
    logic [7:0]  fall_curve [CURVE_LEN];
    logic [2:0]  chan_phase [NUM_CHANNELS];
    logic [15:0] chan_timer [NUM_CHANNELS];
    logic [14:0] chan_level [NUM_CHANNELS];
    params_t     chan_settings [NUM_CHANNELS];
    result_t     expected_results [$];

    initial
    begin : build_curves
        int unsigned radicand;
        int unsigned root;
        fail_count = 0;
        pending = 0;
        for (int i = 0; i < CURVE_LEN; i++)
        begin
            radicand = 12544 * i;
            root = 0;
            while ((root + 1) * (root + 1) <= radicand)
                root++;
            rise_curve[i] = 8'(root / 10);
            fall_curve[i] = 8'(13950 / (i + 50) - 24);
        end
    end

    function automatic result_t apply_event(item_t ev);
        result_t     res;
        params_t     p;
        logic [2:0]  ph;
        logic [15:0] tmr;
        logic [14:0] lvl;
        int unsigned idx;
        int unsigned c;
        c = 32'(ev.channel);
        res.out_channel = ev.channel;
        res.amplitude = '0;
        res.phase = PH_OFF;
        if (c >= NUM_CHANNELS)
            return res;
        p = chan_settings[c];
        ph = chan_phase[c];
        tmr = chan_timer[c];
        lvl = chan_level[c];
        case (ev.op)
            OP_TICK:
            begin
                case (ph)
                    PH_ATTACK:
                    begin
                        if (p.att_rate == 0)
                        begin
                            lvl = LEVEL_MAX;
                            ph = PH_DECAY;
                        end
                        else
                        begin
                            idx = (32'(tmr) << 2) / 32'(p.att_rate);
                            if (idx < CURVE_END)
                            begin
                                lvl = 15'(32'(rise_curve[idx]) << 7);
                                tmr = tmr + 16'd1;
                            end
                            else
                            begin
                                lvl = LEVEL_MAX;
                                ph = PH_DECAY;
                                tmr = '0;
                            end
                        end
                    end
                    PH_DECAY:
                    begin
                        if (p.dec_rate == 0)
                        begin
                            lvl = 15'(32'(p.sus_level) << 8);
                            ph = PH_SUSTAIN;
                        end
                        else
                        begin
                            idx = (32'(tmr) << 2) / 32'(p.dec_rate);
                            if (idx < CURVE_END)
                            begin
                                lvl = 15'((32'(p.sus_level) << 8)
                                          + (32'(SUSTAIN_MAX) - 32'(p.sus_level))
                                          * 32'(fall_curve[idx]));
                                tmr = tmr + 16'd1;
                            end
                            else
                            begin
                                lvl = 15'(32'(p.sus_level) << 8);
                                ph = PH_SUSTAIN;
                            end
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (p.rel_rate == 0 || tmr == TIMER_MAX)
                        begin
                            lvl = '0;
                            ph = PH_OFF;
                        end
                        else
                        begin
                            idx = (32'(tmr) << 2) / 32'(p.rel_rate);
                            if (idx < CURVE_END)
                            begin
                                lvl = 15'(32'(p.sus_level) * 32'(fall_curve[idx]));
                                tmr = tmr + 16'd1;
                            end
                            else
                            begin
                                lvl = '0;
                                ph = PH_OFF;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_TRIGGER:
            begin
                p.att_rate = ev.attack_rate;
                p.dec_rate = ev.decay_rate;
                p.sus_level = ev.sustain_level;
                p.rel_rate = ev.release_rate;
                ph = PH_ATTACK;
                lvl = '0;
                tmr = '0;
            end
            OP_RELEASE:
            begin
                if (ph != PH_OFF)
                begin
                    ph = PH_RELEASE;
                    tmr = '0;
                end
            end
            default:
            begin
                if (ph != PH_OFF)
                begin
                    ph = PH_OFF;
                    lvl = '0;
                    tmr = '0;
                end
            end
        endcase
        chan_settings[c] = p;
        chan_phase[c] = ph;
        chan_timer[c] = tmr;
        chan_level[c] = lvl;
        res.amplitude = lvl;
        res.phase = ph;
        return res;
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_phase[i] = PH_OFF;
                chan_timer[i] = '0;
                chan_level[i] = '0;
                chan_settings[i] = '0;
            end
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: expected no beat, got channel %0d amplitude %0d phase %0d",
                             $time, result.out_channel, result.amplitude, result.phase);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_channel", 32'(want.out_channel),
                                32'(result.out_channel));
                    check_field("amplitude", 32'(want.amplitude), 32'(result.amplitude));
                    check_field("phase", 32'(want.phase), 32'(result.phase));
                end
            end
            if (item_valid && item_ready)
                expected_results.push_back(apply_event(item));
            pending = expected_results.size();
        end
    end

endmodule

// ----- verif/adsr_envelope_generator_unit_tb.sv -----
`timescale 1ns / 1ps

module adsr_envelope_generator_unit_tb;

    import adsr_pkg::*;

    localparam int NUM_CHANNELS = 8;
    localparam int DIRECTED_BEATS = 25;
    localparam int TOTAL_BEATS = DIRECTED_BEATS + 1200;
    localparam int QUIET_FROM = TOTAL_BEATS - 150;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      fail_count;
    int      pending;
    int      beats_sent = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;

    adsr_envelope_generator_unit #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    adsr_envelope_generator_unit_checker #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) envelope_check (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("adsr_envelope_generator_unit: mismatch");
            $finish;
        end
    end

    function automatic item_t make_event(logic [1:0] op, logic [2:0] ch, logic [6:0] att,
                                         logic [6:0] dec, logic [6:0] sus, logic [6:0] rel);
        item_t ev;
        ev.op = op;
        ev.channel = ch;
        ev.attack_rate = att;
        ev.decay_rate = dec;
        ev.sustain_level = sus;
        ev.release_rate = rel;
        return ev;
    endfunction

    function automatic item_t aimed(logic [1:0] op, logic [2:0] ch);
        item_t ev;
        ev = item_t'(33'({$urandom, $urandom}));
        ev.op = op;
        ev.channel = ch;
        return ev;
    endfunction

    function automatic logic [6:0] pick_rate();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 7'd0;
            4, 5, 6: return 7'($urandom_range(1, 2));
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // Each call ends at a falling edge with valid left high, so the next beat
    // or the idle burst makes the only change to valid in that step.
    task automatic send_beat(input item_t beat);
        quiet = (beats_sent >= QUIET_FROM);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic run_ticks(input logic [2:0] ch);
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
        for (int k = 0; k < n && beats_sent < TOTAL_BEATS; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(aimed(OP_TICK, 3'($urandom_range(0, NUM_CHANNELS - 1))));
            else
                send_beat(aimed(OP_TICK, ch));
        end
    endtask

    initial
    begin : receiver
        int stall;
        bit held;
        stall = 0;
        held = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else if (!held && beats_sent >= HOLD_AT)
            begin
                held = 1'b1;
                stall = HOLD_CYCLES - 1;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 13);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        logic [2:0] ch;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_beat(make_event(OP_TICK, 3'd0, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_RELEASE, 3'd1, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_FORCE_OFF, 3'd2, 7'd0, 7'd0, 7'd0, 7'd0));

        send_beat(make_event(OP_TRIGGER, 3'd0, 7'd0, 7'd0, 7'd127, 7'd0));
        send_beat(make_event(OP_TICK, 3'd0, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_TICK, 3'd0, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_RELEASE, 3'd0, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_TICK, 3'd0, 7'd0, 7'd0, 7'd0, 7'd0));

        send_beat(make_event(OP_TRIGGER, 3'd7, 7'd127, 7'd127, 7'd0, 7'd127));
        send_beat(make_event(OP_TICK, 3'd7, 7'd127, 7'd127, 7'd127, 7'd127));
        send_beat(make_event(OP_TICK, 3'd7, 7'd127, 7'd127, 7'd127, 7'd127));
        send_beat(make_event(OP_RELEASE, 3'd7, 7'd127, 7'd127, 7'd127, 7'd127));
        send_beat(make_event(OP_TICK, 3'd7, 7'd127, 7'd127, 7'd127, 7'd127));
        send_beat(make_event(OP_FORCE_OFF, 3'd7, 7'd127, 7'd127, 7'd127, 7'd127));

        send_beat(make_event(OP_TRIGGER, 3'd5, 7'd0, 7'd1, 7'd42, 7'd0));
        send_beat(make_event(OP_TICK, 3'd5, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_TICK, 3'd5, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_RELEASE, 3'd5, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_TICK, 3'd5, 7'd0, 7'd0, 7'd0, 7'd0));

        send_beat(make_event(OP_TRIGGER, 3'd3, 7'd1, 7'd2, 7'd85, 7'd1));
        send_beat(make_event(OP_TICK, 3'd3, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_TRIGGER, 3'd3, 7'd2, 7'd1, 7'd0, 7'd3));
        send_beat(make_event(OP_TICK, 3'd3, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_FORCE_OFF, 3'd3, 7'd0, 7'd0, 7'd0, 7'd0));
        send_beat(make_event(OP_RELEASE, 3'd3, 7'd0, 7'd0, 7'd0, 7'd0));

        while (beats_sent < TOTAL_BEATS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                ch = 3'($urandom_range(0, NUM_CHANNELS - 1));
                send_beat(make_event(OP_TRIGGER, ch, pick_rate(), pick_rate(),
                                     7'($urandom_range(0, 127)), pick_rate()));
                run_ticks(ch);
                if ($urandom_range(0, 2) != 0)
                begin
                    send_beat(aimed(OP_RELEASE, ch));
                    run_ticks(ch);
                end
                if ($urandom_range(0, 3) == 0)
                    send_beat(aimed(OP_FORCE_OFF, ch));
            end
            else
            begin
                send_beat(item_t'(33'({$urandom, $urandom})));
            end
        end
        item_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("adsr_envelope_generator_unit: match");
        else
            $display("adsr_envelope_generator_unit: mismatch");
        $finish;
    end

endmodule

// ----- adsr_envelope_generator_unit.f -----
rtl/adsr_pkg.sv
rtl/adsr_ram.sv
rtl/adsr_envelope_generator_unit.sv
verif/adsr_envelope_generator_unit_checker.sv
verif/adsr_envelope_generator_unit_tb.sv
